### design/event_counter_threshold_alarm_assert.svh
// Assertion macros shared by the event counter modules.
`ifndef EVENT_COUNTER_THRESHOLD_ALARM_ASSERT_SVH
`define EVENT_COUNTER_THRESHOLD_ALARM_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent.
`define ECA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define ECA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/eca_pkg.sv
// Types and constants shared by the event counter modules.
package eca_pkg;

  localparam int unsigned CNT_W   = 10;
  localparam int unsigned TICK_W  = 8;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned SEL_W   = 2;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned CIDX_W  = 2;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_BUTTON = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ALARM  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SCAN   = 2'd2;

  // Display selects
  localparam logic [SEL_W-1:0] SEL_UNITS    = 2'd0;
  localparam logic [SEL_W-1:0] SEL_TENS     = 2'd1;
  localparam logic [SEL_W-1:0] SEL_HUNDREDS = 2'd2;
  localparam logic [SEL_W-1:0] SEL_UNUSED   = 2'd3;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_FLOOR   = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_CEILING = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_LIMIT   = 2'd2;
  localparam logic [CIDX_W-1:0] CFG_TICKS   = 2'd3;

  // Reset values
  localparam logic [CNT_W-1:0]  RST_FLOOR   = 10'd50;
  localparam logic [CNT_W-1:0]  RST_CEILING = 10'd400;
  localparam logic [CNT_W-1:0]  RST_LIMIT   = 10'd999;
  localparam logic [TICK_W-1:0] RST_TICKS   = 8'd5;
  localparam logic [CNT_W-1:0]  RST_COUNT   = 10'd50;

  localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              btn_one;
    logic              btn_two;
    logic              btn_three;
  } eca_item_t;

  typedef struct packed {
    logic [CNT_W-1:0]  floor_v;
    logic [CNT_W-1:0]  ceiling_v;
    logic [CNT_W-1:0]  limit_v;
    logic [TICK_W-1:0] ticks_v;
  } eca_cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0]   count_value;
    logic               counting_mode;
    logic               enable_led;
    logic               alarm_on;
    logic [DIGIT_W-1:0] digit_value;
    logic [SEL_W-1:0]   digit_select;
    logic [CNT_W-1:0]   threshold_value;
  } eca_result_t;

endpackage

### design/event_counter_threshold_alarm.sv
// Top level of the event counter with threshold alarm and display scan.
//
// Each item (button sample, alarm timer tick or display scan tick) passes an
// input register, one pass of compare and increment logic in the state update,
// and a result register; exactly one result leaves for every item. The block
// takes one item per clock cycle unless the result side stalls; an item moves on
// from the input register when the result register is free or being emptied;
// the pair of registers lets a new item in while a result still waits.
// Digits for the scan are split from the count by constant reciprocal
// multiplication in the same pass. Configuration writes take effect at once and
// belong in quiet periods with no item inside the block. No clearing pass.
`include "event_counter_threshold_alarm_assert.svh"

module event_counter_threshold_alarm import eca_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [CNT_W-1:0]   cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [KIND_W-1:0]  in_kind,
  input  logic               in_btn_one_level,
  input  logic               in_btn_two_level,
  input  logic               in_btn_three_level,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CNT_W-1:0]   out_count_value,
  output logic               out_counting_mode,
  output logic               out_enable_led,
  output logic               out_alarm_on,
  output logic [DIGIT_W-1:0] out_digit_value,
  output logic [SEL_W-1:0]   out_digit_select,
  output logic [CNT_W-1:0]   out_threshold_value
);

  eca_cfg_t    cfg_r;
  eca_item_t   in_item;
  eca_item_t   s_item;
  logic        s_valid;
  logic        take;
  logic        fire;
  eca_result_t res;
  eca_result_t res_r;
  logic        out_valid_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.floor_v   <= RST_FLOOR;
      cfg_r.ceiling_v <= RST_CEILING;
      cfg_r.limit_v   <= RST_LIMIT;
      cfg_r.ticks_v   <= RST_TICKS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FLOOR:   cfg_r.floor_v   <= cfg_wdata;
        CFG_CEILING: cfg_r.ceiling_v <= cfg_wdata;
        CFG_LIMIT:   cfg_r.limit_v   <= cfg_wdata;
        CFG_TICKS:   cfg_r.ticks_v   <= cfg_wdata[TICK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_item = '{kind: in_kind, btn_one: in_btn_one_level,
                     btn_two: in_btn_two_level, btn_three: in_btn_three_level};

  eca_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_item  (in_item),
    .in_ready (in_ready),
    .take     (take),
    .s_valid  (s_valid),
    .s_item   (s_item)
  );

  // Move an item on when the result register is free or being emptied
  assign take = !out_valid_r || out_ready;
  assign fire = s_valid && take;

  eca_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (s_item),
    .cfg   (cfg_r),
    .res   (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_count_value     = res_r.count_value;
  assign out_counting_mode   = res_r.counting_mode;
  assign out_enable_led      = res_r.enable_led;
  assign out_alarm_on        = res_r.alarm_on;
  assign out_digit_value     = res_r.digit_value;
  assign out_digit_select    = res_r.digit_select;
  assign out_threshold_value = res_r.threshold_value;

  `ECA_ASSERT_NEXT(a_stalled_item_held, s_valid && !take, s_valid, "held item dropped")
  `ECA_ASSERT_NOW(a_digit_decimal, out_valid_r, out_digit_value <= DIGIT_MAX, "digit above nine")
  `ECA_ASSERT_NOW(a_alarm_mode, out_valid_r && out_alarm_on, out_counting_mode, "alarm in set-up")

endmodule

### design/eca_in_stage.sv
// Input register stage of the event counter.
module eca_in_stage import eca_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  eca_item_t in_item,
  output logic      in_ready,
  input  logic      take,
  output logic      s_valid,
  output eca_item_t s_item
);

  logic      valid_r;
  eca_item_t item_r;

  // Refill whenever the held item moves on or the stage is empty
  assign in_ready = !valid_r || take;
  assign s_valid  = valid_r;
  assign s_item   = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Capture the payload of an accepted item
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

### design/eca_core.sv
// Counter, alarm and display scan state with its single-pass update.
`include "event_counter_threshold_alarm_assert.svh"

module eca_core import eca_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  eca_item_t   item,
  input  eca_cfg_t    cfg,
  output eca_result_t res
);

  // State; a single alarm flag serves as both the alarm flag and its running flag
  logic               mode_r,  mode_nxt;
  logic [CNT_W-1:0]   cnt_r,   cnt_nxt;
  logic [CNT_W-1:0]   thr_r,   thr_nxt;
  logic               en_r,    en_nxt;
  logic [2:0]         last_r,  last_nxt;
  logic               alarm_r, alarm_nxt;
  logic [TICK_W-1:0]  tick_r,  tick_nxt;
  logic [SEL_W-1:0]   sel_r,   sel_nxt;
  logic [DIGIT_W-1:0] dig_r,   dig_nxt;

  logic               fell_one, fell_two, fell_three;
  logic [CNT_W:0]     setup_inc;
  logic [CNT_W-1:0]   cnt_cleared;
  logic [CNT_W:0]     event_inc;
  logic [TICK_W-1:0]  tick_sum;

  logic [15:0]        prod_h;
  logic [3:0]         hund_raw;
  logic [DIGIT_W-1:0] dig_hund;
  logic [CNT_W-1:0]   rem_full;
  logic [6:0]         rem;
  logic [14:0]        prod_t;
  logic [DIGIT_W-1:0] dig_tens;
  logic [DIGIT_W-1:0] dig_units;

  // Falling edges against the last sampled levels
  assign fell_one   = last_r[0] && !item.btn_one;
  assign fell_two   = last_r[1] && !item.btn_two;
  assign fell_three = last_r[2] && !item.btn_three;

  assign setup_inc   = {1'b0, cnt_r} + 11'd1;
  assign cnt_cleared = fell_one ? '0 : cnt_r;
  assign event_inc   = {1'b0, cnt_cleared} + 11'd1;
  assign tick_sum    = tick_r + 8'd1;

  // Split the count into decimal digits by reciprocal multiplication
  assign prod_h    = 16'(cnt_r) * 16'd41;
  assign hund_raw  = prod_h[15:12];
  assign dig_hund  = (hund_raw == 4'd10) ? 4'd0 : hund_raw;
  assign rem_full  = cnt_r - 10'(10'(hund_raw) * 10'd100);
  assign rem       = rem_full[6:0];
  assign prod_t    = 15'(rem) * 15'd205;
  assign dig_tens  = prod_t[14:11];
  assign dig_units = 4'(rem - 7'(7'(dig_tens) * 7'd10));

  // Work out the state after one item
  always_comb begin
    mode_nxt  = mode_r;
    cnt_nxt   = cnt_r;
    thr_nxt   = thr_r;
    en_nxt    = en_r;
    last_nxt  = last_r;
    alarm_nxt = alarm_r;
    tick_nxt  = tick_r;
    sel_nxt   = sel_r;
    dig_nxt   = dig_r;
    unique case (item.kind)
      KIND_BUTTON: begin
        if (!mode_r) begin
          // Set-up: step the value, then maybe store it and start counting
          if (fell_one) begin
            cnt_nxt = (setup_inc > {1'b0, cfg.ceiling_v}) ? cfg.floor_v : setup_inc[CNT_W-1:0];
          end
          last_nxt[1:0] = {item.btn_two, item.btn_one};
          if (fell_two) begin
            thr_nxt  = cnt_nxt;
            cnt_nxt  = '0;
            mode_nxt = 1'b1;
          end
        end else begin
          // Counting: clear, toggle enable, count, then check the alarm
          en_nxt = en_r ^ fell_two;
          if (en_nxt && fell_three) begin
            cnt_nxt = (event_inc > {1'b0, cfg.limit_v}) ? '0 : event_inc[CNT_W-1:0];
          end else begin
            cnt_nxt = cnt_cleared;
          end
          last_nxt = {item.btn_three, item.btn_two, item.btn_one};
          if (cnt_nxt >= thr_r && !alarm_r) begin
            alarm_nxt = 1'b1;
          end
        end
      end
      KIND_ALARM: begin
        if (alarm_r) begin
          if (tick_sum >= cfg.ticks_v) begin
            alarm_nxt = 1'b0;
            tick_nxt  = '0;
          end else begin
            tick_nxt  = tick_sum;
          end
        end
      end
      KIND_SCAN: begin
        unique case (sel_r)
          SEL_TENS: begin
            dig_nxt = dig_hund;
            sel_nxt = SEL_HUNDREDS;
          end
          SEL_HUNDREDS: begin
            dig_nxt = dig_units;
            sel_nxt = SEL_UNITS;
          end
          default: begin
            dig_nxt = dig_tens;
            sel_nxt = SEL_TENS;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // Advance the state on each item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      cnt_r   <= RST_COUNT;
      thr_r   <= '0;
      en_r    <= 1'b1;
      last_r  <= 3'b111;
      alarm_r <= 1'b0;
      tick_r  <= '0;
      sel_r   <= SEL_UNITS;
      dig_r   <= '0;
    end else if (fire) begin
      mode_r  <= mode_nxt;
      cnt_r   <= cnt_nxt;
      thr_r   <= thr_nxt;
      en_r    <= en_nxt;
      last_r  <= last_nxt;
      alarm_r <= alarm_nxt;
      tick_r  <= tick_nxt;
      sel_r   <= sel_nxt;
      dig_r   <= dig_nxt;
    end
  end

  // The result shows the state after the item
  always_comb begin
    res.count_value     = cnt_nxt;
    res.counting_mode   = mode_nxt;
    res.enable_led      = en_nxt;
    res.alarm_on        = alarm_nxt;
    res.digit_value     = dig_nxt;
    res.digit_select    = sel_nxt;
    res.threshold_value = thr_nxt;
  end

  `ECA_ASSERT_NEXT(a_mode_sticks, mode_r, mode_r, "counting mode was left")
  `ECA_ASSERT_NOW(a_alarm_in_counting, alarm_r, mode_r, "alarm on outside counting mode")
  `ECA_ASSERT_NOW(a_sel_valid, 1'b1, sel_r != SEL_UNUSED, "scan pointer on unused code")

endmodule

### test/event_counter_threshold_alarm_tb.sv
// Self-checking testbench for the event counter with threshold alarm and display scan.
`timescale 1ns / 100ps

module event_counter_threshold_alarm_tb;
  import eca_pkg::*;

  localparam int HALF_PERIOD   = 10;
  localparam int RESET_CYCLES  = 4;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int REPORT_MAX    = 10;
  localparam int PHASE_ITEMS   = 120;
  localparam int HOLD_CYCLES   = 60;

  // Kind code with no effect on the state
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

  localparam logic MODE_SETUP = 1'b0;
  localparam logic MODE_COUNT = 1'b1;

  // Outputs straight after reset, before any item has changed the state
  localparam eca_result_t RESET_VIEW = '{
    count_value:     RST_COUNT,
    counting_mode:   MODE_SETUP,
    enable_led:      1'b1,
    alarm_on:        1'b0,
    digit_value:     '0,
    digit_select:    SEL_UNITS,
    threshold_value: '0
  };

  typedef struct packed {
    logic              is_write;
    logic [CIDX_W-1:0] reg_idx;
    logic [CNT_W-1:0]  reg_val;
    eca_item_t         itm;
    logic              pinned;
  } plan_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CIDX_W-1:0]  cfg_index = CFG_FLOOR;
  logic [CNT_W-1:0]   cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [KIND_W-1:0]  in_kind = KIND_BUTTON;
  logic               in_btn_one_level = 1'b1;
  logic               in_btn_two_level = 1'b1;
  logic               in_btn_three_level = 1'b1;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [CNT_W-1:0]   out_count_value;
  logic               out_counting_mode;
  logic               out_enable_led;
  logic               out_alarm_on;
  logic [DIGIT_W-1:0] out_digit_value;
  logic [SEL_W-1:0]   out_digit_select;
  logic [CNT_W-1:0]   out_threshold_value;

  // Marks an item whose expected outputs are the reset view
  logic pin_on = 1'b0;

  int          gap_pct = 0;
  int          stall_pct = 0;
  int          hold_left = 0;
  int unsigned faults = 0;

  eca_result_t result_q[$];

  // Predicted configuration
  logic [CNT_W-1:0]  wrap_floor = RST_FLOOR;
  logic [CNT_W-1:0]  wrap_ceiling = RST_CEILING;
  logic [CNT_W-1:0]  event_limit = RST_LIMIT;
  logic [TICK_W-1:0] alarm_len = RST_TICKS;

  // Predicted state
  logic               mode_now = MODE_SETUP;
  logic [CNT_W-1:0]   count_now = RST_COUNT;
  logic [CNT_W-1:0]   threshold_now = '0;
  logic               enable_now = 1'b1;
  logic [2:0]         prev_levels = 3'b111;
  logic               alarm_now = 1'b0;
  logic               alarm_running = 1'b0;
  logic [TICK_W-1:0]  alarm_ticks_seen = '0;
  logic [DIGIT_W-1:0] digit_now = '0;
  logic [SEL_W-1:0]   select_now = SEL_UNITS;

  event_counter_threshold_alarm dut (.*);

  always #HALF_PERIOD clk = ~clk;

  // Advance the predicted state by one item and return the outputs it shows
  function automatic eca_result_t step_counter(input eca_item_t itm);
    logic [CNT_W:0] bumped;
    logic           enter;
    int unsigned    shown;
    eca_result_t    res;
    enter = 1'b0;
    case (itm.kind)
      KIND_BUTTON: begin
        if (mode_now == MODE_SETUP) begin
          enter = prev_levels[1] && !itm.btn_two;
          if (prev_levels[0] && !itm.btn_one) begin
            bumped = {1'b0, count_now} + 1'b1;
            count_now = (bumped > {1'b0, wrap_ceiling}) ? wrap_floor : bumped[CNT_W-1:0];
          end
          // button three is ignored here and keeps its old level
          prev_levels[1:0] = {itm.btn_two, itm.btn_one};
          // entering counting mode skips the alarm check
          if (enter) begin
            threshold_now = count_now;
            count_now = '0;
            mode_now = MODE_COUNT;
          end
        end else begin
          if (prev_levels[0] && !itm.btn_one)
            count_now = '0;
          if (prev_levels[1] && !itm.btn_two)
            enable_now = !enable_now;
          if (enable_now && prev_levels[2] && !itm.btn_three) begin
            bumped = {1'b0, count_now} + 1'b1;
            count_now = (bumped > {1'b0, event_limit}) ? '0 : bumped[CNT_W-1:0];
          end
          prev_levels = {itm.btn_three, itm.btn_two, itm.btn_one};
          if (count_now >= threshold_now && !alarm_now) begin
            alarm_now = 1'b1;
            alarm_running = 1'b1;
          end
        end
      end
      KIND_ALARM: begin
        if (alarm_running) begin
          alarm_ticks_seen = alarm_ticks_seen + 1'b1;
          if (alarm_ticks_seen >= alarm_len) begin
            alarm_now = 1'b0;
            alarm_running = 1'b0;
            alarm_ticks_seen = '0;
          end
        end
      end
      KIND_SCAN: begin
        // the select doubles as the scan pointer: units, then tens, then hundreds
        shown = 32'(count_now);
        case (select_now)
          SEL_TENS: begin
            digit_now = DIGIT_W'(shown / 100 % 10);
            select_now = SEL_HUNDREDS;
          end
          SEL_HUNDREDS: begin
            digit_now = DIGIT_W'(shown % 10);
            select_now = SEL_UNITS;
          end
          default: begin
            digit_now = DIGIT_W'(shown / 10 % 10);
            select_now = SEL_TENS;
          end
        endcase
      end
      default: ;
    endcase
    res.count_value = count_now;
    res.counting_mode = mode_now;
    res.enable_led = enable_now;
    res.alarm_on = alarm_now;
    res.digit_value = digit_now;
    res.digit_select = select_now;
    res.threshold_value = threshold_now;
    return res;
  endfunction

  function automatic plan_row_t btn_row(input logic [KIND_W-1:0] kind, input logic one,
                                        input logic two, input logic three);
    plan_row_t row;
    row = '0;
    row.itm.kind = kind;
    row.itm.btn_one = one;
    row.itm.btn_two = two;
    row.itm.btn_three = three;
    return row;
  endfunction

  function automatic plan_row_t reg_row(input logic [CIDX_W-1:0] idx,
                                        input logic [CNT_W-1:0] val);
    plan_row_t row;
    row = '0;
    row.is_write = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    row.itm.btn_one = 1'b1;
    row.itm.btn_two = 1'b1;
    row.itm.btn_three = 1'b1;
    return row;
  endfunction

  // Buttons one and two mostly released, so that presses form clean falling edges
  function automatic eca_item_t random_item();
    int unsigned pick;
    eca_item_t   itm;
    pick = $urandom_range(99);
    if (pick < 55)
      itm.kind = KIND_BUTTON;
    else if (pick < 80)
      itm.kind = KIND_ALARM;
    else if (pick < 95)
      itm.kind = KIND_SCAN;
    else
      itm.kind = KIND_NONE;
    itm.btn_one = ($urandom_range(9) != 0);
    itm.btn_two = ($urandom_range(7) != 0);
    itm.btn_three = 1'($urandom_range(1));
    return itm;
  endfunction

  // Offer one item, idling first as the sender gap allows, and hold it until taken
  task automatic offer_item(input eca_item_t itm, input logic pinned);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= itm.kind;
    in_btn_one_level <= itm.btn_one;
    in_btn_two_level <= itm.btn_two;
    in_btn_three_level <= itm.btn_three;
    pin_on <= pinned;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CNT_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_FLOOR:   wrap_floor = val;
      CFG_CEILING: wrap_ceiling = val;
      CFG_LIMIT:   event_limit = val;
      CFG_TICKS:   alarm_len = val[TICK_W-1:0];
      default: ;
    endcase
  endtask

  task automatic run_phase(input int gap, input int stall, input logic [CNT_W-1:0] lo,
                           input logic [CNT_W-1:0] hi, input logic [CNT_W-1:0] lim,
                           input logic [TICK_W-1:0] len, input logic hold, input logic pause);
    int        sent;
    eca_item_t itm;
    drain_results();
    write_reg(CFG_FLOOR, lo);
    write_reg(CFG_CEILING, hi);
    write_reg(CFG_LIMIT, lim);
    write_reg(CFG_TICKS, {2'b00, len});
    gap_pct = gap;
    stall_pct = stall;
    if (hold)
      hold_left = HOLD_CYCLES;
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      itm = random_item();
      offer_item(itm, 1'b0);
      if (itm.kind != KIND_NONE)
        sent++;
      if (pause && sent == PHASE_ITEMS / 2)
        drain_results();
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      faults++;
      if (faults <= REPORT_MAX)
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Stall the result side, with a long hold-off when one is requested
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left = hold_left - 1;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Predict on every item taken, check every result delivered
  always @(posedge clk) begin : watch
    eca_item_t   seen;
    eca_result_t got;
    eca_result_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        seen.kind = in_kind;
        seen.btn_one = in_btn_one_level;
        seen.btn_two = in_btn_two_level;
        seen.btn_three = in_btn_three_level;
        want = step_counter(seen);
        result_q.push_back(pin_on ? RESET_VIEW : want);
      end
      if (out_valid && out_ready) begin
        got.count_value = out_count_value;
        got.counting_mode = out_counting_mode;
        got.enable_led = out_enable_led;
        got.alarm_on = out_alarm_on;
        got.digit_value = out_digit_value;
        got.digit_select = out_digit_select;
        got.threshold_value = out_threshold_value;
        if (result_q.size() == 0) begin
          faults++;
          if (faults <= REPORT_MAX)
            $display("%0t: result with none expected, count_value %0d", $time,
                     got.count_value);
        end else begin
          want = result_q.pop_front();
          check_field("count_value", 32'(want.count_value), 32'(got.count_value));
          check_field("counting_mode", 32'(want.counting_mode), 32'(got.counting_mode));
          check_field("enable_led", 32'(want.enable_led), 32'(got.enable_led));
          check_field("alarm_on", 32'(want.alarm_on), 32'(got.alarm_on));
          check_field("digit_value", 32'(want.digit_value), 32'(got.digit_value));
          check_field("digit_select", 32'(want.digit_select), 32'(got.digit_select));
          check_field("threshold_value", 32'(want.threshold_value),
                      32'(got.threshold_value));
        end
      end
    end
  end

  // Give up on a hang
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("event_counter_threshold_alarm: mismatch");
    $finish;
  end

  initial begin
    plan_row_t plan[$];
    plan = '{
      // set-up with the floor above the ceiling
      reg_row(CFG_CEILING, 10'd52), reg_row(CFG_FLOOR, 10'd998),
      btn_row(KIND_NONE,   1'b1, 1'b1, 1'b1),
      btn_row(KIND_SCAN,   1'b1, 1'b1, 1'b1),
      btn_row(KIND_ALARM,  1'b1, 1'b1, 1'b1),
      // step up with button three held down, which set-up ignores
      btn_row(KIND_BUTTON, 1'b0, 1'b1, 1'b0), btn_row(KIND_BUTTON, 1'b1, 1'b1, 1'b0),
      btn_row(KIND_BUTTON, 1'b0, 1'b1, 1'b0), btn_row(KIND_BUTTON, 1'b1, 1'b1, 1'b0),
      btn_row(KIND_BUTTON, 1'b0, 1'b1, 1'b0), btn_row(KIND_BUTTON, 1'b1, 1'b1, 1'b0),
      btn_row(KIND_BUTTON, 1'b0, 1'b1, 1'b0), btn_row(KIND_BUTTON, 1'b1, 1'b1, 1'b0),
      // top of the range, then a wrap to a zero floor and zero alarm ticks
      reg_row(CFG_CEILING, 10'd999), reg_row(CFG_FLOOR, 10'd0), reg_row(CFG_TICKS, 10'd0),
      btn_row(KIND_BUTTON, 1'b0, 1'b1, 1'b0),
      btn_row(KIND_SCAN,   1'b1, 1'b1, 1'b0), btn_row(KIND_SCAN, 1'b1, 1'b1, 1'b0),
      btn_row(KIND_SCAN,   1'b1, 1'b1, 1'b0),
      btn_row(KIND_BUTTON, 1'b1, 1'b1, 1'b0), btn_row(KIND_BUTTON, 1'b0, 1'b1, 1'b0),
      btn_row(KIND_BUTTON, 1'b1, 1'b1, 1'b0),
      // enter counting mode; the held button three now counts on the next sample
      btn_row(KIND_BUTTON, 1'b1, 1'b0, 1'b0), btn_row(KIND_BUTTON, 1'b1, 1'b1, 1'b0),
      btn_row(KIND_ALARM,  1'b1, 1'b1, 1'b0), btn_row(KIND_ALARM, 1'b1, 1'b1, 1'b0),
      // disable, count while disabled, clear
      btn_row(KIND_BUTTON, 1'b1, 1'b0, 1'b1), btn_row(KIND_BUTTON, 1'b1, 1'b1, 1'b0),
      btn_row(KIND_BUTTON, 1'b0, 1'b1, 1'b1),
      btn_row(KIND_NONE,   1'b0, 1'b0, 1'b0)
    };
    // the first item must still show the reset state
    plan[2].pinned = 1'b1;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        drain_results();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        offer_item(plan[i].itm, plan[i].pinned);
      end
    end

    // no idling, widest limits, long receiver hold-off at the start
    run_phase(0, 0, 10'd0, 10'd999, 10'd999, 8'd255, 1'b1, 1'b0);
    // sender gaps, tightest limits
    run_phase(66, 0, 10'd999, 10'd0, 10'd1, 8'd1, 1'b0, 1'b0);
    // receiver stalls, small random limits
    run_phase(0, 66, CNT_W'($urandom_range(999)), CNT_W'($urandom_range(999)),
              CNT_W'($urandom_range(30, 2)), TICK_W'($urandom_range(8, 1)), 1'b0, 1'b0);
    // both sides idle, sender pauses for a full drain halfway
    run_phase(34, 34, CNT_W'($urandom_range(999)), CNT_W'($urandom_range(999)),
              CNT_W'($urandom_range(999, 1)), TICK_W'($urandom_range(255, 1)), 1'b0, 1'b1);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (faults == 0)
      $display("event_counter_threshold_alarm: match");
    else
      $display("event_counter_threshold_alarm: mismatch");
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/eca_pkg.sv
design/eca_in_stage.sv
design/eca_core.sv
design/event_counter_threshold_alarm.sv
test/event_counter_threshold_alarm_tb.sv
